// File: rtl/ffa_pkg.sv
// shared types, codes and defaults of the first-fit free list allocator
`default_nettype none
package ffa_pkg;

    localparam int HEAP_UNITS_DEF = 65536;
    localparam int GROW_UNITS_DEF = 1024;

    localparam int REQ_W    = 20;
    localparam int UNIT_W   = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int LOG2_W   = 3;
    localparam int MINC_W   = 7;
    localparam int LIMIT_W  = 17;

    localparam logic [LOG2_W-1:0]  UNIT_LOG2_RST = 3'd4;
    localparam logic [MINC_W-1:0]  MIN_CHUNK_RST = 7'd3;
    localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 17'd65536;

    localparam logic [1:0] REG_UNIT_LOG2  = 2'd0;
    localparam logic [1:0] REG_MIN_CHUNK  = 2'd1;
    localparam logic [1:0] REG_HEAP_LIMIT = 2'd2;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STS_ALLOCATED = 2'd0,
        STS_RELEASED  = 2'd1,
        STS_IGNORED   = 2'd2,
        STS_NO_MEM    = 2'd3
    } status_t;

    typedef struct packed {
        logic [LOG2_W-1:0]  unit_size_log2;
        logic [MINC_W-1:0]  min_chunk_units;
        logic [LIMIT_W-1:0] heap_limit_units;
    } cfg_t;

    typedef struct packed {
        logic tag;
        logic prev;
        logic next;
    } mem_we_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_WALK_RD, ST_WALK_CK,
        ST_GROW, ST_GROW_INS, ST_GROW_PREV_RD, ST_GROW_PREV_CK, ST_GROW_PB_RD, ST_GROW_PB_CK,
        ST_USE_RD, ST_USE_CK, ST_USE_SET, ST_USE_SPLIT, ST_USE_INS,
        ST_REL_RD, ST_REL_CK, ST_REL_INS, ST_REL_PREV_RD, ST_REL_PREV_CK,
        ST_REL_PB_RD, ST_REL_PB_CK, ST_REL_NEXT_RD, ST_REL_NEXT_CK, ST_REL_NB_RD, ST_REL_NB_CK,
        ST_MRG_RDA, ST_MRG_RDB, ST_MRG_RMA, ST_MRG_RMB, ST_MRG_SET, ST_MRG_INS,
        ST_RM_RD, ST_RM_P, ST_RM_N,
        ST_INS_0, ST_INS_1,
        ST_SC_0, ST_SC_1,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/ffa_cfg.sv
// apb configuration registers of the allocator
`default_nettype none
module ffa_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ffa_pkg::APB_AW-1:0] paddr,
    input  wire logic [ffa_pkg::APB_DW-1:0] pwdata,
    output logic      [ffa_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output ffa_pkg::cfg_t                   cfg
);

    ffa_pkg::cfg_t cfg_reg;
    logic [1:0]    idx;
    logic          wr;

    assign idx    = paddr[3:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_size_log2   <= ffa_pkg::UNIT_LOG2_RST;
            cfg_reg.min_chunk_units  <= ffa_pkg::MIN_CHUNK_RST;
            cfg_reg.heap_limit_units <= ffa_pkg::HEAP_LIMIT_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                ffa_pkg::REG_UNIT_LOG2:
                    cfg_reg.unit_size_log2 <= pwdata[ffa_pkg::LOG2_W-1:0];
                ffa_pkg::REG_MIN_CHUNK:
                    cfg_reg.min_chunk_units <= pwdata[ffa_pkg::MINC_W-1:0];
                ffa_pkg::REG_HEAP_LIMIT:
                    cfg_reg.heap_limit_units <= pwdata[ffa_pkg::LIMIT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ffa_pkg::REG_UNIT_LOG2:
                prdata = ffa_pkg::APB_DW'(cfg_reg.unit_size_log2);
            ffa_pkg::REG_MIN_CHUNK:
                prdata = ffa_pkg::APB_DW'(cfg_reg.min_chunk_units);
            ffa_pkg::REG_HEAP_LIMIT:
                prdata = ffa_pkg::APB_DW'(cfg_reg.heap_limit_units);
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/ffa_store.sv
// tag and link memories with one shared address and registered read
`default_nettype none
module ffa_store #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    localparam int AW = $clog2(HEAP_UNITS),
    localparam int PW = AW + 1,
    localparam int SW = AW + 1,
    localparam int NW = (AW + 2 > 21) ? AW + 2 : 21
) (
    input  wire logic            clk,
    input  wire logic [NW-1:0]   addr,
    input  wire ffa_pkg::mem_we_t we,
    input  wire logic [SW:0]     tag_w,
    input  wire logic [PW-1:0]   prev_w,
    input  wire logic [PW-1:0]   next_w,
    output logic      [SW:0]     tag_r,
    output logic      [PW-1:0]   prev_r,
    output logic      [PW-1:0]   next_r
);

    logic [SW:0]   tag_mem  [HEAP_UNITS];
    logic [PW-1:0] prev_mem [HEAP_UNITS];
    logic [PW-1:0] next_mem [HEAP_UNITS];

    logic [SW:0]   tag_q;
    logic [PW-1:0] prev_q;
    logic [PW-1:0] next_q;
    logic          range_q;
    logic          in_range;
    logic [AW-1:0] idx;

    assign in_range = addr < NW'(HEAP_UNITS);
    assign idx      = addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_range)
        begin
            if (we.tag)
                tag_mem[idx] <= tag_w;
            if (we.prev)
                prev_mem[idx] <= prev_w;
            if (we.next)
                next_mem[idx] <= next_w;
        end
        tag_q   <= tag_mem[idx];
        prev_q  <= prev_mem[idx];
        next_q  <= next_mem[idx];
        range_q <= in_range;
    end

    // outside the heap a tag reads zero and a link reads null
    assign tag_r  = range_q ? tag_q  : '0;
    assign prev_r = range_q ? prev_q : '1;
    assign next_r = range_q ? next_q : '1;

endmodule
`default_nettype wire

// File: rtl/ffa_seq.sv
// sequencer and datapath that walk and edit the free list
`default_nettype none
module ffa_seq #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int GROW_UNITS = ffa_pkg::GROW_UNITS_DEF,
    localparam int AW = $clog2(HEAP_UNITS),
    localparam int PW = AW + 1,
    localparam int SW = AW + 1,
    localparam int NW = (AW + 2 > 21) ? AW + 2 : 21
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ffa_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        kind,
    input  wire logic [ffa_pkg::REQ_W-1:0]   request_bytes,
    input  wire logic [ffa_pkg::UNIT_W-1:0]  release_unit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [1:0]                  status,
    output logic      [ffa_pkg::UNIT_W-1:0]  payload_unit,
    output logic      [NW-1:0]               m_addr,
    output ffa_pkg::mem_we_t                 m_we,
    output logic      [SW:0]                 m_tag_w,
    output logic      [PW-1:0]               m_prev_w,
    output logic      [PW-1:0]               m_next_w,
    input  wire logic [SW:0]                 m_tag_r,
    input  wire logic [PW-1:0]               m_prev_r,
    input  wire logic [PW-1:0]               m_next_r
);

    localparam logic [PW-1:0] NIL = '1;

    ffa_pkg::state_t  state_reg, state_next;
    ffa_pkg::state_t  ret_reg, ret_next;
    ffa_pkg::state_t  mret_reg, mret_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [SW-1:0]    hend_reg, hend_next;
    logic             out_valid_reg, out_valid_next;

    logic [NW-1:0]    need_reg, need_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    fnd_reg, fnd_next;
    logic [NW-1:0]    aux_reg, aux_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic [NW-1:0]    sa_reg, sa_next;
    logic [NW-1:0]    sb_reg, sb_next;
    logic [NW-1:0]    arga_reg, arga_next;
    logic [NW-1:0]    argu_reg, argu_next;
    logic             argb_reg, argb_next;
    logic [PW-1:0]    rmp_reg, rmp_next;
    logic [PW-1:0]    rmn_reg, rmn_next;
    logic [NW-1:0]    ma_reg, ma_next;
    logic [NW-1:0]    mb_reg, mb_next;
    ffa_pkg::status_t st_reg, st_next;
    logic [ffa_pkg::UNIT_W-1:0] pay_reg, pay_next;
    ffa_pkg::status_t sts_out_reg, sts_out_next;
    logic [ffa_pkg::UNIT_W-1:0] pay_out_reg, pay_out_next;

    logic [NW-1:0]    r_size;
    logic             r_busy;
    logic [NW-1:0]    rnd;
    logic [NW-1:0]    need_calc;
    logic [NW-1:0]    gneed;
    logic [NW-1:0]    cap;
    logic [NW-1:0]    minc;
    logic [NW-1:0]    hend_n;

    assign r_size    = NW'(m_tag_r[SW:1]);
    assign r_busy    = m_tag_r[0];
    assign rnd       = NW'(request_bytes) + (NW'(1) << cfg.unit_size_log2) - NW'(1);
    assign need_calc = (rnd >> cfg.unit_size_log2) + NW'(2);
    assign gneed     = (need_reg < NW'(GROW_UNITS)) ? NW'(GROW_UNITS) : need_reg;
    assign cap       = (NW'(cfg.heap_limit_units) < NW'(HEAP_UNITS))
                       ? NW'(cfg.heap_limit_units) : NW'(HEAP_UNITS);
    assign minc      = (cfg.min_chunk_units == '0) ? NW'(1) : NW'(cfg.min_chunk_units);
    assign hend_n    = NW'(hend_reg);

    assign in_stall     = state_reg != ffa_pkg::ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign status       = sts_out_reg;
    assign payload_unit = pay_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffa_pkg::ST_IDLE;
            ret_reg       <= ffa_pkg::ST_IDLE;
            mret_reg      <= ffa_pkg::ST_IDLE;
            head_reg      <= NIL;
            hend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            mret_reg      <= mret_next;
            head_reg      <= head_next;
            hend_reg      <= hend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg    <= need_next;
        cur_reg     <= cur_next;
        fnd_reg     <= fnd_next;
        aux_reg     <= aux_next;
        cnt_reg     <= cnt_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        arga_reg    <= arga_next;
        argu_reg    <= argu_next;
        argb_reg    <= argb_next;
        rmp_reg     <= rmp_next;
        rmn_reg     <= rmn_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        st_reg      <= st_next;
        pay_reg     <= pay_next;
        sts_out_reg <= sts_out_next;
        pay_out_reg <= pay_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        mret_next      = mret_reg;
        head_next      = head_reg;
        hend_next      = hend_reg;
        out_valid_next = out_valid_reg;
        need_next      = need_reg;
        cur_next       = cur_reg;
        fnd_next       = fnd_reg;
        aux_next       = aux_reg;
        cnt_next       = cnt_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        arga_next      = arga_reg;
        argu_next      = argu_reg;
        argb_next      = argb_reg;
        rmp_next       = rmp_reg;
        rmn_next       = rmn_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        st_next        = st_reg;
        pay_next       = pay_reg;
        sts_out_next   = sts_out_reg;
        pay_out_next   = pay_out_reg;
        m_addr         = '0;
        m_we           = '0;
        m_tag_w        = '0;
        m_prev_w       = '0;
        m_next_w       = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pay_next = '0;
                    if (kind == ffa_pkg::KIND_ALLOC)
                    begin
                        if (request_bytes == '0)
                        begin
                            st_next    = ffa_pkg::STS_IGNORED;
                            state_next = ffa_pkg::ST_DONE;
                        end
                        else
                        begin
                            need_next  = need_calc;
                            cur_next   = (head_reg == NIL) ? '1 : NW'(head_reg);
                            cnt_next   = '0;
                            state_next = ffa_pkg::ST_WALK_RD;
                        end
                    end
                    else
                    begin
                        if (release_unit == '0)
                        begin
                            st_next    = ffa_pkg::STS_IGNORED;
                            state_next = ffa_pkg::ST_DONE;
                        end
                        else
                        begin
                            cur_next   = NW'(release_unit) - NW'(1);
                            state_next = ffa_pkg::ST_REL_RD;
                        end
                    end
                end
            end

            // first-fit walk, one list entry per read
            ffa_pkg::ST_WALK_RD:
            begin
                if (cur_reg >= NW'(HEAP_UNITS) || NW'(cnt_reg) >= NW'(HEAP_UNITS))
                    state_next = ffa_pkg::ST_GROW;
                else
                begin
                    m_addr     = cur_reg;
                    state_next = ffa_pkg::ST_WALK_CK;
                end
            end
            ffa_pkg::ST_WALK_CK:
            begin
                if (r_size >= need_reg)
                begin
                    fnd_next   = cur_reg;
                    state_next = ffa_pkg::ST_USE_RD;
                end
                else
                begin
                    cur_next   = (m_next_r == NIL) ? '1 : NW'(m_next_r);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ffa_pkg::ST_WALK_RD;
                end
            end

            ffa_pkg::ST_GROW:
            begin
                if (hend_n > cap || gneed > cap - hend_n)
                begin
                    st_next    = ffa_pkg::STS_NO_MEM;
                    state_next = ffa_pkg::ST_DONE;
                end
                else
                begin
                    cur_next   = hend_n;
                    hend_next  = SW'(hend_n + gneed);
                    arga_next  = hend_n;
                    argu_next  = gneed;
                    argb_next  = 1'b0;
                    ret_next   = ffa_pkg::ST_GROW_INS;
                    state_next = ffa_pkg::ST_SC_0;
                end
            end
            ffa_pkg::ST_GROW_INS:
            begin
                arga_next  = cur_reg;
                ret_next   = ffa_pkg::ST_GROW_PREV_RD;
                state_next = ffa_pkg::ST_INS_0;
            end
            ffa_pkg::ST_GROW_PREV_RD:
            begin
                fnd_next = cur_reg;
                if (cur_reg == '0)
                    state_next = ffa_pkg::ST_USE_RD;
                else
                begin
                    m_addr     = cur_reg - NW'(1);
                    state_next = ffa_pkg::ST_GROW_PREV_CK;
                end
            end
            ffa_pkg::ST_GROW_PREV_CK:
            begin
                if (r_size == '0 || r_size > cur_reg)
                    state_next = ffa_pkg::ST_USE_RD;
                else
                begin
                    aux_next   = cur_reg - r_size;
                    state_next = ffa_pkg::ST_GROW_PB_RD;
                end
            end
            ffa_pkg::ST_GROW_PB_RD:
            begin
                m_addr     = aux_reg;
                state_next = ffa_pkg::ST_GROW_PB_CK;
            end
            ffa_pkg::ST_GROW_PB_CK:
            begin
                if (!r_busy)
                begin
                    fnd_next   = aux_reg;
                    ma_next    = aux_reg;
                    mb_next    = cur_reg;
                    mret_next  = ffa_pkg::ST_USE_RD;
                    state_next = ffa_pkg::ST_MRG_RDA;
                end
                else
                    state_next = ffa_pkg::ST_USE_RD;
            end

            // take the chunk, split when the rest is big enough
            ffa_pkg::ST_USE_RD:
            begin
                m_addr     = fnd_reg;
                state_next = ffa_pkg::ST_USE_CK;
            end
            ffa_pkg::ST_USE_CK:
            begin
                sa_next    = r_size;
                arga_next  = fnd_reg;
                ret_next   = ffa_pkg::ST_USE_SET;
                state_next = ffa_pkg::ST_RM_RD;
            end
            ffa_pkg::ST_USE_SET:
            begin
                st_next    = ffa_pkg::STS_ALLOCATED;
                pay_next   = ffa_pkg::UNIT_W'(fnd_reg + NW'(1));
                arga_next  = fnd_reg;
                argb_next  = 1'b1;
                state_next = ffa_pkg::ST_SC_0;
                if (sa_reg < need_reg + minc)
                begin
                    argu_next = sa_reg;
                    ret_next  = ffa_pkg::ST_DONE;
                end
                else
                begin
                    argu_next = need_reg;
                    ret_next  = ffa_pkg::ST_USE_SPLIT;
                end
            end
            ffa_pkg::ST_USE_SPLIT:
            begin
                arga_next  = fnd_reg + need_reg;
                argu_next  = sa_reg - need_reg;
                argb_next  = 1'b0;
                ret_next   = ffa_pkg::ST_USE_INS;
                state_next = ffa_pkg::ST_SC_0;
            end
            ffa_pkg::ST_USE_INS:
            begin
                arga_next  = fnd_reg + need_reg;
                ret_next   = ffa_pkg::ST_DONE;
                state_next = ffa_pkg::ST_INS_0;
            end

            // release and coalesce
            ffa_pkg::ST_REL_RD:
            begin
                m_addr     = cur_reg;
                state_next = ffa_pkg::ST_REL_CK;
            end
            ffa_pkg::ST_REL_CK:
            begin
                if (cur_reg >= hend_n || !r_busy || r_size == '0 || r_size > hend_n - cur_reg)
                begin
                    st_next    = ffa_pkg::STS_IGNORED;
                    state_next = ffa_pkg::ST_DONE;
                end
                else
                begin
                    st_next    = ffa_pkg::STS_RELEASED;
                    arga_next  = cur_reg;
                    argu_next  = r_size;
                    argb_next  = 1'b0;
                    ret_next   = ffa_pkg::ST_REL_INS;
                    state_next = ffa_pkg::ST_SC_0;
                end
            end
            ffa_pkg::ST_REL_INS:
            begin
                arga_next  = cur_reg;
                ret_next   = ffa_pkg::ST_REL_PREV_RD;
                state_next = ffa_pkg::ST_INS_0;
            end
            ffa_pkg::ST_REL_PREV_RD:
            begin
                if (cur_reg == '0)
                    state_next = ffa_pkg::ST_REL_NEXT_RD;
                else
                begin
                    m_addr     = cur_reg - NW'(1);
                    state_next = ffa_pkg::ST_REL_PREV_CK;
                end
            end
            ffa_pkg::ST_REL_PREV_CK:
            begin
                if (r_size == '0 || r_size > cur_reg)
                    state_next = ffa_pkg::ST_REL_NEXT_RD;
                else
                begin
                    aux_next   = cur_reg - r_size;
                    state_next = ffa_pkg::ST_REL_PB_RD;
                end
            end
            ffa_pkg::ST_REL_PB_RD:
            begin
                m_addr     = aux_reg;
                state_next = ffa_pkg::ST_REL_PB_CK;
            end
            ffa_pkg::ST_REL_PB_CK:
            begin
                if (!r_busy)
                begin
                    ma_next    = aux_reg;
                    mb_next    = cur_reg;
                    cur_next   = aux_reg;
                    mret_next  = ffa_pkg::ST_REL_NEXT_RD;
                    state_next = ffa_pkg::ST_MRG_RDA;
                end
                else
                    state_next = ffa_pkg::ST_REL_NEXT_RD;
            end
            ffa_pkg::ST_REL_NEXT_RD:
            begin
                m_addr     = cur_reg;
                state_next = ffa_pkg::ST_REL_NEXT_CK;
            end
            ffa_pkg::ST_REL_NEXT_CK:
            begin
                if (r_size == '0 || cur_reg + r_size >= hend_n)
                    state_next = ffa_pkg::ST_DONE;
                else
                begin
                    aux_next   = cur_reg + r_size;
                    state_next = ffa_pkg::ST_REL_NB_RD;
                end
            end
            ffa_pkg::ST_REL_NB_RD:
            begin
                m_addr     = aux_reg;
                state_next = ffa_pkg::ST_REL_NB_CK;
            end
            ffa_pkg::ST_REL_NB_CK:
            begin
                if (!r_busy)
                begin
                    ma_next    = cur_reg;
                    mb_next    = aux_reg;
                    mret_next  = ffa_pkg::ST_DONE;
                    state_next = ffa_pkg::ST_MRG_RDA;
                end
                else
                    state_next = ffa_pkg::ST_DONE;
            end

            // merge b into a
            ffa_pkg::ST_MRG_RDA:
            begin
                m_addr     = ma_reg;
                state_next = ffa_pkg::ST_MRG_RDB;
            end
            ffa_pkg::ST_MRG_RDB:
            begin
                sa_next    = r_size;
                m_addr     = mb_reg;
                state_next = ffa_pkg::ST_MRG_RMA;
            end
            ffa_pkg::ST_MRG_RMA:
            begin
                sb_next    = r_size;
                arga_next  = ma_reg;
                ret_next   = ffa_pkg::ST_MRG_RMB;
                state_next = ffa_pkg::ST_RM_RD;
            end
            ffa_pkg::ST_MRG_RMB:
            begin
                arga_next  = mb_reg;
                ret_next   = ffa_pkg::ST_MRG_SET;
                state_next = ffa_pkg::ST_RM_RD;
            end
            ffa_pkg::ST_MRG_SET:
            begin
                arga_next  = ma_reg;
                argu_next  = sa_reg + sb_reg;
                argb_next  = 1'b0;
                ret_next   = ffa_pkg::ST_MRG_INS;
                state_next = ffa_pkg::ST_SC_0;
            end
            ffa_pkg::ST_MRG_INS:
            begin
                arga_next  = ma_reg;
                ret_next   = mret_reg;
                state_next = ffa_pkg::ST_INS_0;
            end

            // unlink from the free list
            ffa_pkg::ST_RM_RD:
            begin
                m_addr     = arga_reg;
                state_next = ffa_pkg::ST_RM_P;
            end
            ffa_pkg::ST_RM_P:
            begin
                rmp_next = m_prev_r;
                rmn_next = m_next_r;
                if (m_prev_r != NIL)
                begin
                    m_addr      = NW'(m_prev_r);
                    m_we.next   = 1'b1;
                    m_next_w    = m_next_r;
                end
                else
                    head_next = m_next_r;
                state_next = ffa_pkg::ST_RM_N;
            end
            ffa_pkg::ST_RM_N:
            begin
                if (rmn_reg != NIL)
                begin
                    m_addr    = NW'(rmn_reg);
                    m_we.prev = 1'b1;
                    m_prev_w  = rmp_reg;
                end
                state_next = ret_reg;
            end

            // push at the list head
            ffa_pkg::ST_INS_0:
            begin
                m_addr     = arga_reg;
                m_we.prev  = 1'b1;
                m_we.next  = 1'b1;
                m_prev_w   = NIL;
                m_next_w   = head_reg;
                state_next = ffa_pkg::ST_INS_1;
            end
            ffa_pkg::ST_INS_1:
            begin
                if (head_reg != NIL)
                begin
                    m_addr    = NW'(head_reg);
                    m_we.prev = 1'b1;
                    m_prev_w  = PW'(arga_reg);
                end
                head_next  = PW'(arga_reg);
                state_next = ret_reg;
            end

            // header and footer tags
            ffa_pkg::ST_SC_0:
            begin
                m_addr     = arga_reg;
                m_we.tag   = 1'b1;
                m_tag_w    = {SW'(argu_reg), argb_reg};
                state_next = ffa_pkg::ST_SC_1;
            end
            ffa_pkg::ST_SC_1:
            begin
                if (argu_reg != '0)
                begin
                    m_addr   = arga_reg + argu_reg - NW'(1);
                    m_we.tag = 1'b1;
                    m_tag_w  = {SW'(argu_reg), argb_reg};
                end
                state_next = ret_reg;
            end

            ffa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sts_out_next   = st_reg;
                    pay_out_next   = (st_reg == ffa_pkg::STS_ALLOCATED) ? pay_reg : '0;
                    state_next     = ffa_pkg::ST_IDLE;
                end
            end

            default:
                state_next = ffa_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/first_fit_free_list_allocator_core.sv
// top level of the first-fit free list heap allocator
//
//  channel  direction  handshake                       payload
//  in       sink       in_valid / in_stall             kind, request_bytes, release_unit
//  out      source     out_valid / out_stall           status, payload_unit
//  cfg      apb slave  psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// one beat at a time: an allocation walks the free list entry by entry, may grow the
// heap and merge, and splits the chunk when the rest is big enough; a release may
// merge with both neighbours. the pace is set by the single-port tag and link
// memories, one access a cycle.
// reset clears list head, heap size, state and config; memories need no clearing pass.
// a result waits in the output register under out_stall while the next beat is accepted.
`default_nettype none
module first_fit_free_list_allocator_core #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int GROW_UNITS = ffa_pkg::GROW_UNITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ffa_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ffa_pkg::APB_DW-1:0]  pwdata,
    output logic      [ffa_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        kind,
    input  wire logic [ffa_pkg::REQ_W-1:0]   request_bytes,
    input  wire logic [ffa_pkg::UNIT_W-1:0]  release_unit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [1:0]                  status,
    output logic      [ffa_pkg::UNIT_W-1:0]  payload_unit
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int PW = AW + 1;
    localparam int SW = AW + 1;
    localparam int NW = (AW + 2 > 21) ? AW + 2 : 21;

    ffa_pkg::cfg_t    cfg;
    ffa_pkg::mem_we_t m_we;
    logic [NW-1:0]    m_addr;
    logic [SW:0]      m_tag_w;
    logic [PW-1:0]    m_prev_w;
    logic [PW-1:0]    m_next_w;
    logic [SW:0]      m_tag_r;
    logic [PW-1:0]    m_prev_r;
    logic [PW-1:0]    m_next_r;

    ffa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ffa_store #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_store (
        .clk    (clk),
        .addr   (m_addr),
        .we     (m_we),
        .tag_w  (m_tag_w),
        .prev_w (m_prev_w),
        .next_w (m_next_w),
        .tag_r  (m_tag_r),
        .prev_r (m_prev_r),
        .next_r (m_next_r)
    );

    ffa_seq #(
        .HEAP_UNITS (HEAP_UNITS),
        .GROW_UNITS (GROW_UNITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .request_bytes (request_bytes),
        .release_unit  (release_unit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .payload_unit  (payload_unit),
        .m_addr        (m_addr),
        .m_we          (m_we),
        .m_tag_w       (m_tag_w),
        .m_prev_w      (m_prev_w),
        .m_next_w      (m_next_w),
        .m_tag_r       (m_tag_r),
        .m_prev_r      (m_prev_r),
        .m_next_r      (m_next_r)
    );

endmodule
`default_nettype wire

// File: rtl/ffa_checker.sv
// port-level checks of the allocator and their bind
`default_nettype none
module ffa_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [1:0]                 status,
    input wire logic [ffa_pkg::UNIT_W-1:0] payload_unit,
    input wire logic                       pready
);

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffa_pkg::STS_ALLOCATED |-> payload_unit == '0)
        else $error("payload nonzero on a non-allocation result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_unit))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a beat");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (.*);
`default_nettype wire
